[rtl/sts_pkg.sv]
`timescale 1ns / 1ps

package sts_pkg;

    localparam int LENGTH_BITS  = 12;
    localparam int LINE_BITS    = 20;
    localparam int COLUMN_BITS  = 12;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam int TAB_BITS     = 3;

    localparam logic [TAB_BITS-1:0]    TAB_RESET = TAB_BITS'(3);
    localparam logic                   REG_TAB_STOP = 1'b0;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_INT    = 3'd2;
    localparam logic [2:0] KIND_DOUBLE = 3'd3;
    localparam logic [2:0] KIND_NAME   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_CHAR_END  = 2'd0;
    localparam logic [1:0] ERR_CHAR_OPEN = 2'd1;
    localparam logic [1:0] ERR_STR_END   = 2'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_CH_OPEN,
        MODE_CH_ESC,
        MODE_CH_CLOSE,
        MODE_STR,
        MODE_STR_ESC,
        MODE_WORD
    } sts_mode_t;

    typedef struct packed {
        logic digits;
        logic minus;
        logic dec;
        logic dot;
        logic hexpre;
        logic hexok;
    } sts_flags_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } sts_in_t;

    typedef struct packed {
        logic [2:0]             token_kind;
        logic [1:0]             error_code;
        logic [7:0]             char_value;
        logic [LENGTH_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic                   last_result;
    } sts_out_t;

    typedef struct packed {
        logic [1:0] n;
        sts_out_t   r0;
        sts_out_t   r1;
    } sts_push_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_USCORE);
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h62:   r = 8'd8;
            8'h74:   r = 8'd9;
            8'h6E:   r = 8'd10;
            8'h66:   r = 8'd12;
            8'h72:   r = 8'd13;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic sts_flags_t word_flags(sts_flags_t f, logic [LENGTH_BITS-1:0] idx,
                                              logic [7:0] c);
        sts_flags_t r;
        logic       dig;
        dig = is_digit(c);
        r   = f;
        if (idx == '0)
        begin
            r        = '0;
            r.digits = dig;
            r.minus  = (c == CH_MINUS);
            r.dec    = dig || (c == CH_MINUS);
            r.hexpre = (c == CH_ZERO);
            r.hexok  = 1'b1;
        end
        else
        begin
            if (!dig)
                r.digits = 1'b0;
            if (c == CH_DOT)
                r.dot = 1'b1;
            else if (!dig)
                r.dec = 1'b0;
            if ((idx == LENGTH_BITS'(1)) && (c != CH_X))
                r.hexpre = 1'b0;
            if ((idx >= LENGTH_BITS'(2)) && !is_hex(c))
                r.hexok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [2:0] word_kind(sts_flags_t f, logic [LENGTH_BITS-1:0] len);
        logic       hex_path;
        logic       min_ok;
        logic [2:0] k;
        hex_path = f.hexpre && (len >= LENGTH_BITS'(2));
        min_ok   = f.minus ? (len > LENGTH_BITS'(1)) : (len != '0);
        if (hex_path && (len > LENGTH_BITS'(2)) && f.hexok)
            k = KIND_INT;
        else if (!hex_path && f.dec && !f.dot && min_ok)
            k = KIND_INT;
        else if (f.dot && f.dec)
            k = KIND_DOUBLE;
        else
            k = KIND_NAME;
        return k;
    endfunction

    function automatic sts_out_t make_result(logic [2:0] kind, logic [1:0] err, logic [7:0] ch,
                                             logic [LENGTH_BITS-1:0] len,
                                             logic [LINE_BITS-1:0] line,
                                             logic [COLUMN_BITS-1:0] col, logic last);
        sts_out_t r;
        r.token_kind   = kind;
        r.error_code   = err;
        r.char_value   = ch;
        r.token_length = len;
        r.start_line   = line;
        r.start_column = col;
        r.last_result  = last;
        return r;
    endfunction

endpackage

[rtl/sts_core.sv]
`timescale 1ns / 1ps

module sts_core
    import sts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sts_in_t             in_data,
    input  logic [TAB_BITS-1:0] tab_stop_log2,
    input  logic                room,
    output sts_push_t           push
);

    localparam int TW = COLUMN_BITS + 8;

    logic                   in_vld_reg,  in_vld_next;
    sts_in_t                in_data_reg;
    sts_mode_t              mode_reg,    mode_next;
    sts_flags_t             flags_reg,   flags_next;
    logic [7:0]             pend_reg,    pend_next;
    logic [LENGTH_BITS-1:0] len_reg,     len_next;
    logic [LINE_BITS-1:0]   tline_reg,   tline_next;
    logic [COLUMN_BITS-1:0] tcol_reg,    tcol_next;
    logic [LINE_BITS-1:0]   line_reg,    line_next;
    logic [COLUMN_BITS-1:0] col_reg,     col_next;

    logic                   proceed;
    logic [7:0]             c;
    logic                   eot;
    logic                   cont;
    logic                   punct;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [LINE_BITS-1:0]   mv_line;
    logic [COLUMN_BITS-1:0] mv_col;
    logic [TW-1:0]          tab_step;
    logic [TW-1:0]          col_tab;

    assign proceed  = in_vld_reg && room;
    assign in_ready = !in_vld_reg || room;
    assign c        = in_data_reg.text_byte;
    assign eot      = in_data_reg.end_of_text;
    assign cont     = is_word(c) || ((c == CH_DOT) && flags_reg.digits);
    assign punct    = (c == CH_COMMA) || (c == CH_DOT);
    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + LENGTH_BITS'(1);

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
            in_vld_next = 1'b1;
        else if (proceed)
            in_vld_next = 1'b0;
    end

    // position after consuming the byte
    always_comb
    begin
        tab_step = TW'(1) << tab_stop_log2;
        col_tab  = (TW'(col_reg) + tab_step) & ~(tab_step - TW'(1));
        mv_line  = line_reg;
        mv_col   = col_reg;
        if (c == CH_NL)
        begin
            mv_line = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_BITS'(1);
            mv_col  = '0;
        end
        else if (c == CH_TAB)
            mv_col = (col_tab > TW'(COL_MAX)) ? COL_MAX : col_tab[COLUMN_BITS-1:0];
        else if (col_reg != COL_MAX)
            mv_col = col_reg + COLUMN_BITS'(1);
    end

    function automatic sts_mode_t mode_start(logic [7:0] b);
        sts_mode_t m;
        if (b == CH_QUOTE)
            m = MODE_CH_OPEN;
        else if (b == CH_DQUOTE)
            m = MODE_STR;
        else if ((b == CH_COMMA) || (b == CH_DOT))
            m = MODE_IDLE;
        else
            m = MODE_WORD;
        return m;
    endfunction

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (proceed)
        begin
            if (eot)
                mode_next = MODE_IDLE;
            else
            begin
                case (mode_reg)
                    MODE_WORD:     mode_next = cont ? MODE_WORD : mode_start(c);
                    MODE_CH_OPEN:  mode_next = (c == CH_BSLASH) ? MODE_CH_ESC : MODE_CH_CLOSE;
                    MODE_CH_ESC:   mode_next = MODE_CH_CLOSE;
                    MODE_CH_CLOSE: mode_next = MODE_IDLE;
                    MODE_STR:
                    begin
                        if (c == CH_DQUOTE)
                            mode_next = MODE_IDLE;
                        else if (c == CH_BSLASH)
                            mode_next = MODE_STR_ESC;
                        else
                            mode_next = MODE_STR;
                    end
                    MODE_STR_ESC:  mode_next = MODE_STR;
                    default:       mode_next = mode_start(c);
                endcase
            end
        end
    end

    // datapath and results
    always_comb
    begin
        logic start_new;
        start_new  = 1'b0;
        flags_next = flags_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        push.n     = 2'd0;
        push.r0    = make_result(KIND_NAME, ERR_NONE, 8'd0, len_reg, tline_reg, tcol_reg, 1'b1);
        push.r1    = push.r0;
        if (proceed)
        begin
            if (eot)
            begin
                line_next = LINE_BITS'(1);
                col_next  = '0;
                case (mode_reg)
                    MODE_CH_OPEN, MODE_CH_ESC, MODE_CH_CLOSE:
                    begin
                        push.r0 = make_result(KIND_ERROR, ERR_CHAR_END, 8'd0, len_reg,
                                              tline_reg, tcol_reg, 1'b1);
                        push.n  = 2'd1;
                    end
                    MODE_STR, MODE_STR_ESC:
                    begin
                        push.r0 = make_result(KIND_ERROR, ERR_STR_END, 8'd0, len_reg,
                                              tline_reg, tcol_reg, 1'b1);
                        push.n  = 2'd1;
                    end
                    MODE_WORD:
                    begin
                        push.r0 = make_result(word_kind(flags_reg, len_reg), ERR_NONE, 8'd0,
                                              len_reg, tline_reg, tcol_reg, 1'b1);
                        push.n  = 2'd1;
                    end
                    default:
                        push.n = 2'd0;
                endcase
            end
            else
            begin
                line_next = mv_line;
                col_next  = mv_col;
                case (mode_reg)
                    MODE_WORD:
                    begin
                        if (cont)
                        begin
                            flags_next = word_flags(flags_reg, len_reg, c);
                            len_next   = len_inc;
                        end
                        else
                        begin
                            push.r0   = make_result(word_kind(flags_reg, len_reg), ERR_NONE,
                                                    8'd0, len_reg, tline_reg, tcol_reg, !punct);
                            push.n    = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_CH_OPEN:
                    begin
                        len_next = len_inc;
                        if (c != CH_BSLASH)
                            pend_next = c;
                    end
                    MODE_CH_ESC:
                    begin
                        len_next  = len_inc;
                        pend_next = unescape(c);
                    end
                    MODE_CH_CLOSE:
                    begin
                        push.n = 2'd1;
                        if (c == CH_QUOTE)
                        begin
                            len_next = len_inc;
                            push.r0  = make_result(KIND_CHAR, ERR_NONE, pend_reg, len_inc,
                                                   tline_reg, tcol_reg, 1'b1);
                        end
                        else
                            push.r0 = make_result(KIND_ERROR, ERR_CHAR_OPEN, 8'd0, len_reg,
                                                  tline_reg, tcol_reg, 1'b1);
                    end
                    MODE_STR:
                    begin
                        if (c == CH_DQUOTE)
                        begin
                            push.r0 = make_result(KIND_STRING, ERR_NONE, 8'd0, len_reg,
                                                  tline_reg, tcol_reg, 1'b1);
                            push.n  = 2'd1;
                        end
                        else
                            len_next = len_inc;
                    end
                    MODE_STR_ESC:
                        len_next = len_inc;
                    default:
                        start_new = 1'b1;
                endcase

                if (start_new)
                begin
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    if (c == CH_QUOTE)
                    begin
                        len_next  = LENGTH_BITS'(1);
                        pend_next = 8'd0;
                    end
                    else if (c == CH_DQUOTE)
                        len_next = '0;
                    else if (punct)
                    begin
                        len_next = LENGTH_BITS'(1);
                        if (push.n == 2'd0)
                            push.r0 = make_result(KIND_NAME, ERR_NONE, 8'd0, LENGTH_BITS'(1),
                                                  line_reg, col_reg, 1'b1);
                        else
                            push.r1 = make_result(KIND_NAME, ERR_NONE, 8'd0, LENGTH_BITS'(1),
                                                  line_reg, col_reg, 1'b1);
                        push.n = push.n + 2'd1;
                    end
                    else
                    begin
                        flags_next = word_flags(flags_reg, '0, c);
                        len_next   = LENGTH_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            flags_reg  <= '0;
            pend_reg   <= '0;
            len_reg    <= '0;
            tline_reg  <= LINE_BITS'(1);
            tcol_reg   <= '0;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            mode_reg   <= mode_next;
            flags_reg  <= flags_next;
            pend_reg   <= pend_next;
            len_reg    <= len_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

endmodule

[rtl/sts_out_fifo.sv]
`timescale 1ns / 1ps

module sts_out_fifo
    import sts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sts_push_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output sts_out_t  out_data
);

    sts_out_t                mem_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [OUT_PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [OUT_CNT_BITS-1:0] cnt_reg,  cnt_next;
    logic [OUT_PTR_BITS-1:0] wptr_1;
    logic                    pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    // space for two words regardless of this cycle's pop
    assign room      = (cnt_reg <= OUT_CNT_BITS'(OUT_DEPTH - 2));
    assign wptr_1    = wptr_reg + OUT_PTR_BITS'(1);

    always_comb
    begin
        wptr_next = wptr_reg + OUT_PTR_BITS'(push.n);
        rptr_next = pop ? rptr_reg + OUT_PTR_BITS'(1) : rptr_reg;
        cnt_next  = cnt_reg + OUT_CNT_BITS'(push.n) - OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wptr_1] <= push.r1;
    end

endmodule

[rtl/source_token_scanner.sv]
`timescale 1ns / 1ps
// Each accepted byte is registered; its result words are shown from the output queue; a
//   second result (word run closed by comma or dot) is queued right behind the first.
// Throughput: one byte per cycle; the 4-word output queue throttles input only while
//   it holds more than two words.
// Reset: rst_n asynchronous, active low; scanner idle at line 1 column 0, tab stop log2 3.

module source_token_scanner
    import sts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sts_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sts_out_t              out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    logic [TAB_BITS-1:0] tab_reg, tab_next;
    logic                cfg_wr;
    logic                reg_sel;
    logic                room;
    sts_push_t           push;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_BITS-1] == REG_TAB_STOP);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {{(PDATA_BITS - TAB_BITS){1'b0}}, tab_reg} : '0;

    always_comb
    begin
        tab_next = tab_reg;
        if (cfg_wr)
            tab_next = pwdata[TAB_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tab_reg <= TAB_RESET;
        else
            tab_reg <= tab_next;
    end

    sts_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .tab_stop_log2 (tab_reg),
        .room          (room),
        .push          (push)
    );

    sts_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/sts_checker.sv]
`timescale 1ns / 1ps

module sts_checker
    import sts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input sts_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result word changed while stalled");

    a_kind_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.error_code != ERR_NONE) |->
            (out_data.token_kind == KIND_ERROR) && (out_data.error_code != 2'd3))
        else $error("error code on a non-error token");

    a_char_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.char_value != 8'd0) |-> (out_data.token_kind == KIND_CHAR))
        else $error("character value on a non-character token");

    a_line_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.start_line != '0))
        else $error("token start line is zero");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
